// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, codes and the character mapping of the Base64 stream encoder.
package b64e_pkg;

    // Input word operation codes.
    typedef enum logic
    {
        OP_DATA   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_URL_SAFE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_PAD  = 1'b1;

    // Characters used by the mapping.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam int unsigned GROUP_SLOTS = 4;

    // One character position of a group: a six-bit value or a padding mark.
    typedef struct packed
    {
        logic       pad;
        logic [5:0] sextet;
    } slot_t;

    // A group of up to four characters waiting to be sent.
    typedef struct packed
    {
        slot_t [GROUP_SLOTS-1:0] slots;
        logic  [1:0]             last_idx;
    } group_t;

    // Maps a six-bit value to its character in the selected alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url_safe);
        logic [7:0] ch;
        if (v < 6'd26)
        begin
            ch = CHAR_UPPER_A + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            ch = CHAR_LOWER_A + {2'b00, v - 6'd26};
        end
        else if (v < 6'd62)
        begin
            ch = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
        end
        else if (v == 6'd62)
        begin
            ch = url_safe ? CHAR_MINUS : CHAR_PLUS;
        end
        else
        begin
            ch = url_safe ? CHAR_UNDER : CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

// ===== hw/rtl/b64e_pack.sv =====
// Byte hold and group builder of the Base64 stream encoder.
module b64e_pack
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            op,
    input  logic [7:0]      data_byte,
    input  logic            skip_padding,
    input  logic            grp_ready,
    output logic            grp_valid,
    output b64e_pkg::group_t grp
);
    import b64e_pkg::*;

    logic [7:0] held_bytes_reg [2];
    logic [7:0] held_bytes_next [2];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic       needs_group;
    logic       accept;
    logic       is_finish;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] mid_byte;
    logic [7:0] tail_byte;

    assign is_finish = (op == OP_FINISH);
    assign b1 = held_bytes_reg[0];
    assign b2 = held_bytes_reg[1];

    // A word that completes or flushes a group needs the group slot free.
    assign needs_group = is_finish ? (held_count_reg != 2'd0) : (held_count_reg == 2'd2);
    assign in_stall    = needs_group && !grp_ready;
    assign accept      = in_valid && !in_stall;
    assign grp_valid   = accept && needs_group;

    always_comb
    begin
        // Bits beyond the held data are zero on a flush.
        mid_byte  = (!is_finish || held_count_reg == 2'd2) ? b2 : 8'h00;
        tail_byte = is_finish ? 8'h00 : data_byte;

        grp.slots[0].pad    = 1'b0;
        grp.slots[0].sextet = b1[7:2];
        grp.slots[1].pad    = 1'b0;
        grp.slots[1].sextet = {b1[1:0], mid_byte[7:4]};
        grp.slots[2].pad    = is_finish && (held_count_reg == 2'd1);
        grp.slots[2].sextet = {b2[3:0], tail_byte[7:6]};
        grp.slots[3].pad    = is_finish;
        grp.slots[3].sextet = data_byte[5:0];

        if (!is_finish || !skip_padding)
        begin
            grp.last_idx = 2'd3;
        end
        else if (held_count_reg == 2'd1)
        begin
            grp.last_idx = 2'd1;
        end
        else
        begin
            grp.last_idx = 2'd2;
        end
    end

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (!is_finish && held_count_reg != 2'd2)
            begin
                held_bytes_next[held_count_reg[0]] = data_byte;
                held_count_next = held_count_reg + 2'd1;
            end
            else
            begin
                held_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg    <= 2'd0;
            held_bytes_reg[0] <= 8'h00;
            held_bytes_reg[1] <= 8'h00;
        end
        else
        begin
            held_count_reg <= held_count_next;
            held_bytes_reg <= held_bytes_next;
        end
    end

endmodule

// ===== hw/rtl/b64e_serial.sv =====
// Group register and character serialiser of the Base64 stream encoder.
module b64e_serial
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             grp_valid,
    input  b64e_pkg::group_t grp,
    output logic             grp_ready,
    input  logic             url_safe,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_char,
    output logic             run_last
);
    import b64e_pkg::*;

    group_t     grp_reg;
    group_t     grp_next;
    logic       grp_valid_reg;
    logic       grp_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       run_last_reg;
    logic       run_last_next;
    logic       take;
    logic       is_last;
    slot_t      cur_slot;

    assign cur_slot  = grp_reg.slots[idx_reg];
    assign take      = grp_valid_reg && (!out_valid_reg || !out_stall);
    assign is_last   = (idx_reg == grp_reg.last_idx);
    assign grp_ready = !grp_valid_reg || (take && is_last);

    always_comb
    begin
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        if (grp_valid)
        begin
            grp_next       = grp;
            grp_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (take && is_last)
        begin
            grp_valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_slot.pad ? CHAR_PAD : sextet_char(cur_slot.sextet, url_safe);
            run_last_next  = is_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;

endmodule

// ===== hw/rtl/base64_stream_encoder_core.sv =====
// Top level of the Base64 stream encoder: configuration registers and datapath.
//
// Usage. Input words arrive on in_valid/in_stall with op and data_byte; a word
// is taken at a rising edge where in_valid is high and in_stall is low. A data
// word adds a byte to a hold of two; the third byte completes a group of four
// characters. A finish word flushes a partial group with '=' padding unless
// skip padding is set. Characters leave one per word on out_valid/out_stall,
// with run_last high on the final character that an input word produces.
// The first character of a group passes from the group register through the
// output character register. The single character output register sends one
// character per cycle while the receiver does not stall, so three data bytes
// make four characters. Words that only fill the hold are taken every cycle,
// and a word that completes a group is taken as soon as the group register is
// free, which is on the edge that sends the last character of the previous one.
// While the receiver stalls, the output word holds and the group register stays
// full; the input then stalls only for a word that needs a new group.
// Reset clears the hold, the group and output valid flags and both
// configuration bits (standard alphabet, padding on). Configuration is written
// through cfg_we, cfg_index and cfg_data and should change only when idle.
module base64_stream_encoder_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [b64e_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [0:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_char,
    output logic                             run_last
);
    import b64e_pkg::*;

    logic   url_safe_reg;
    logic   url_safe_next;
    logic   skip_padding_reg;
    logic   skip_padding_next;
    logic   grp_valid;
    logic   grp_ready;
    group_t grp;

    // Configuration writes take effect at the next edge.
    always_comb
    begin
        url_safe_next     = url_safe_reg;
        skip_padding_next = skip_padding_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_URL_SAFE: url_safe_next     = cfg_data[0];
                CFG_SKIP_PAD: skip_padding_next = cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_safe_reg     <= 1'b0;
            skip_padding_reg <= 1'b0;
        end
        else
        begin
            url_safe_reg     <= url_safe_next;
            skip_padding_reg <= skip_padding_next;
        end
    end

    // The packer keeps the byte hold and builds a group of six-bit values.
    b64e_pack u_pack
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .data_byte    (data_byte),
        .skip_padding (skip_padding_reg),
        .grp_ready    (grp_ready),
        .grp_valid    (grp_valid),
        .grp          (grp)
    );

    // The serialiser maps each value to a character and sends one per cycle while the output is not stalled.
    b64e_serial u_serial
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp       (grp),
        .grp_ready (grp_ready),
        .url_safe  (url_safe_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_last  (run_last)
    );

endmodule

// ===== hw/rtl/b64e_checker.sv =====
// Port-level checker of the Base64 stream encoder and its bind statement.
module b64e_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       run_last
);
    import b64e_pkg::*;

    // A stalled output word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(run_last))
        else $error("output word changed while stalled");

    // Characters of one run follow without gaps once the run has started.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside a character run");

    // Padding is only ever followed by more padding within a run.
    a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last && out_char == CHAR_PAD
        |=> out_valid && out_char == CHAR_PAD)
        else $error("data character after padding");

    // Every character belongs to one of the alphabets or is padding.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_char >= CHAR_UPPER_A && out_char <= 8'h5A) ||
            (out_char >= CHAR_LOWER_A && out_char <= 8'h7A) ||
            (out_char >= CHAR_DIGIT_0 && out_char <= 8'h39) ||
            out_char == CHAR_PLUS || out_char == CHAR_SLASH ||
            out_char == CHAR_MINUS || out_char == CHAR_UNDER ||
            out_char == CHAR_PAD)
        else $error("character outside the alphabet");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .run_last  (run_last)
);

// ===== bench/base64_stream_encoder_core_tb.sv =====
// Self-checking testbench for the Base64 stream encoder core.
`timescale 1ns / 100ps

module base64_stream_encoder_core_tb;

    import b64e_pkg::*;

    // One input word as the sender queues it.
    typedef struct packed
    {
        op_t        op;
        logic [7:0] data;
    } word_t;

    // One encoded character with its end-of-run flag.
    typedef struct packed
    {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    // How often a side pauses between words.
    typedef enum logic [1:0]
    {
        PACE_NONE,
        PACE_RANDOM,
        PACE_SPARSE
    } pace_t;

    localparam int unsigned MAX_WAIT      = 11;
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_WORDS   = 45;

    // The sixty-two characters that do not depend on the alphabet choice, first one
    // in the top byte.
    localparam logic [62*8-1:0] PLAIN_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_URL_SAFE;
    logic [0:0]             cfg_data  = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   op        = OP_DATA;
    logic [7:0]             data_byte = 8'h00;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             out_char;
    logic                   run_last;

    // Words still to be offered, and characters the encoder still owes us, oldest first.
    word_t     words_to_send[$];
    enc_char_t chars_due[$];

    // Our own copy of the encoder state and its two configuration bits.
    logic [7:0] held[2];
    logic [1:0] held_count;
    logic       url_safe_cfg;
    logic       skip_pad_cfg;

    pace_t       sender_pace   = PACE_NONE;
    pace_t       receiver_pace = PACE_NONE;
    int unsigned holds_asked   = 0;
    int unsigned holds_done;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned idle_cycles;

    int unsigned failures      = 0;
    int unsigned words_taken   = 0;
    int unsigned finishes      = 0;
    int unsigned flushes       = 0;
    int unsigned groups        = 0;
    int unsigned chars_seen    = 0;
    int unsigned settings_used = 0;

    base64_stream_encoder_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_last  (run_last)
    );

    always #5 clk = ~clk;

    // Maps a six-bit value to its character; only the last two depend on the alphabet.
    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        int idx;
        idx = 61 - int'(v);
        if (v == 6'd62)
        begin
            return url_safe_cfg ? CHAR_MINUS : CHAR_PLUS;
        end
        if (v == 6'd63)
        begin
            return url_safe_cfg ? CHAR_UNDER : CHAR_SLASH;
        end
        return PLAIN_SYMBOLS[8*idx +: 8];
    endfunction

    function automatic void owe_char(input logic [7:0] ch, input logic last);
        chars_due.push_back('{ch: ch, last: last});
    endfunction

    // Works out the characters that one accepted word makes the encoder send, and
    // advances our copy of the hold.
    function automatic void encode_word(input word_t w);
        logic [7:0] b1;
        logic [7:0] b2;
        b1 = held[0];
        b2 = held[1];
        if (w.op == OP_DATA)
        begin
            if (held_count < 2'd2)
            begin
                held[held_count[0]] = w.data;
                held_count = held_count + 2'd1;
                return;
            end
            owe_char(symbol_of(b1[7:2]), 1'b0);
            owe_char(symbol_of({b1[1:0], b2[7:4]}), 1'b0);
            owe_char(symbol_of({b2[3:0], w.data[7:6]}), 1'b0);
            owe_char(symbol_of(w.data[5:0]), 1'b1);
            held_count = 2'd0;
            groups++;
            return;
        end
        finishes++;
        if (held_count == 2'd0)
        begin
            return;
        end
        flushes++;
        owe_char(symbol_of(b1[7:2]), 1'b0);
        if (held_count == 2'd1)
        begin
            // One held byte: two characters, then two pad marks unless padding is skipped.
            owe_char(symbol_of({b1[1:0], 4'h0}), skip_pad_cfg);
            if (!skip_pad_cfg)
            begin
                owe_char(CHAR_PAD, 1'b0);
                owe_char(CHAR_PAD, 1'b1);
            end
        end
        else
        begin
            // Two held bytes: three characters, then one pad mark unless padding is skipped.
            owe_char(symbol_of({b1[1:0], b2[7:4]}), 1'b0);
            owe_char(symbol_of({b2[3:0], 2'b00}), skip_pad_cfg);
            if (!skip_pad_cfg)
            begin
                owe_char(CHAR_PAD, 1'b1);
            end
        end
        held_count = 2'd0;
    endfunction

    // Number of cycles a side waits before its next word.
    function automatic int unsigned draw_wait(input pace_t pace);
        case (pace)
            PACE_NONE:   return 0;
            PACE_RANDOM: return $urandom_range(0, MAX_WAIT);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
        endcase
    endfunction

    // Sender. A word stays on the port while it is stalled; once taken it is handed
    // to the predictor, and the next one follows after its own drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            op        <= OP_DATA;
            data_byte <= 8'h00;
            gap_left  <= 0;
        end
        else
        begin : sender
            word_t nxt;
            if (in_valid && !in_stall)
            begin
                encode_word('{op: op_t'(op), data: data_byte});
                words_taken++;
            end
            if (in_valid && in_stall)
            begin
                // Stalled: the word stays exactly as it is.
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (words_to_send.size() != 0)
            begin
                nxt = words_to_send.pop_front();
                op        <= nxt.op;
                data_byte <= nxt.data;
                in_valid  <= 1'b1;
                gap_left  <= draw_wait(sender_pace);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. Each character taken is checked against the oldest one owed; the
    // stall before the next one is drawn afresh. A long hold, when one is asked
    // for, is counted down here so that the sender keeps pushing meanwhile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            holds_done <= 0;
        end
        else
        begin : receiver
            enc_char_t due;
            int unsigned wait_n;
            if (out_valid && !out_stall)
            begin
                chars_seen++;
                if (chars_due.size() == 0)
                begin
                    $error("character 8'h%02h arrived with none owed", out_char);
                    failures++;
                end
                else
                begin
                    due = chars_due.pop_front();
                    if (out_char !== due.ch)
                    begin
                        $error("out_char: expected 8'h%02h, got 8'h%02h", due.ch, out_char);
                        failures++;
                    end
                    if (run_last !== due.last)
                    begin
                        $error("run_last: expected %0b, got %0b", due.last, run_last);
                        failures++;
                    end
                end
            end
            if (holds_done != holds_asked)
            begin
                holds_done <= holds_done + 1;
                hold_left  <= LONG_HOLD;
                out_stall  <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                wait_n = draw_wait(receiver_pace);
                hold_left <= wait_n;
                out_stall <= (wait_n != 0);
            end
            else if (hold_left > 1)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                hold_left <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: the run is given up when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Timed out after %0d cycles without a word moving.", STALL_LIMIT);
            $display("base64_stream_encoder_core_tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_word(input op_t o, input logic [7:0] b);
        words_to_send.push_back('{op: o, data: b});
    endtask

    // Writes both registers on consecutive edges; only called while nothing is owed.
    task automatic write_config(input logic url_safe, input logic skip_pad);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_URL_SAFE;
        cfg_data  <= url_safe;
        @(posedge clk);
        cfg_index <= CFG_SKIP_PAD;
        cfg_data  <= skip_pad;
        @(posedge clk);
        cfg_we <= 1'b0;
        url_safe_cfg = url_safe;
        skip_pad_cfg = skip_pad;
        settings_used++;
    endtask

    // Waits until every queued word is taken and every owed character has come,
    // then lets the encoder drain for a word that made no character.
    task automatic settle();
        @(posedge clk);
        while (words_to_send.size() != 0 || in_valid || chars_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random word: mostly data bytes, with extreme values now and then and a finish
    // roughly one time in six so that all three hold depths meet a flush.
    function automatic word_t random_word();
        word_t w;
        w.op = ($urandom_range(0, 5) == 0) ? OP_FINISH : OP_DATA;
        case ($urandom_range(0, 7))
            0:       w.data = 8'h00;
            1:       w.data = 8'hFF;
            default: w.data = 8'($urandom_range(0, 255));
        endcase
        return w;
    endfunction

    initial
    begin
        held[0]      = 8'h00;
        held[1]      = 8'h00;
        held_count   = 2'd0;
        url_safe_cfg = 1'b0;
        skip_pad_cfg = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words with the standard alphabet and padding on.
        sender_pace   = PACE_RANDOM;
        receiver_pace = PACE_RANDOM;
        write_config(1'b0, 1'b0);
        push_word(OP_FINISH, 8'hA5);        // finish on an empty hold: nothing comes out
        push_word(OP_DATA, 8'h00);
        push_word(OP_DATA, 8'h00);
        push_word(OP_DATA, 8'h00);          // all-zero group
        push_word(OP_DATA, 8'hFB);
        push_word(OP_DATA, 8'hEF);
        push_word(OP_DATA, 8'hBE);          // every sextet is 62
        push_word(OP_DATA, 8'hFF);
        push_word(OP_FINISH, 8'h00);        // one held byte, two pad marks
        push_word(OP_DATA, 8'hFB);
        push_word(OP_DATA, 8'hFF);
        push_word(OP_FINISH, 8'hFF);        // two held bytes, value 63, one pad mark
        push_word(OP_DATA, 8'h12);
        push_word(OP_DATA, 8'h34);          // left in the hold across the next write
        settle();

        // URL-safe alphabet with padding off; the first finish flushes bytes that
        // were taken under the previous setting.
        write_config(1'b1, 1'b1);
        push_word(OP_FINISH, 8'h5A);
        push_word(OP_DATA, 8'hFB);
        push_word(OP_DATA, 8'hFF);
        push_word(OP_FINISH, 8'h00);
        push_word(OP_DATA, 8'hFF);
        push_word(OP_FINISH, 8'h00);
        push_word(OP_DATA, 8'hFB);
        push_word(OP_DATA, 8'hEF);
        push_word(OP_DATA, 8'hBE);
        push_word(OP_DATA, 8'hFF);          // again left in the hold
        settle();

        // Random phases: the four settings in turn, then random ones, with the
        // pacing of both sides varied. One phase holds the receiver off for a long
        // stretch while the sender runs flat out, so the encoder backs up.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 4)
            begin
                write_config(p[0], p[1]);
            end
            else
            begin
                write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            sender_pace   = pace_t'(p % 3);
            receiver_pace = pace_t'((p + 1) % 3);
            if (p == 5)
            begin
                sender_pace = PACE_NONE;
                holds_asked++;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                words_to_send.push_back(random_word());
            end
            settle();
        end

        $display("Covered %0d input words (%0d finish, %0d flushes, %0d full groups),",
                 words_taken, finishes, flushes, groups);
        $display("%0d characters checked under %0d register settings.",
                 chars_seen, settings_used);
        if (failures == 0 && chars_due.size() == 0)
        begin
            $display("base64_stream_encoder_core_tb: PASS");
        end
        else
        begin
            $display("base64_stream_encoder_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_pack.sv
hw/rtl/b64e_serial.sv
hw/rtl/base64_stream_encoder_core.sv
hw/rtl/b64e_checker.sv
bench/base64_stream_encoder_core_tb.sv
